[rtl/pblm_pkg.sv]
// Shared types and constants of the page buffer LRU manager.
`timescale 1ns / 1ps
package pblm_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int SLOT_W        = 6;
   localparam int CSR_DATA_W    = 7;
   localparam int TAG_W         = 48;

   localparam logic [2:0] OP_READ        = 3'd0;
   localparam logic [2:0] OP_NEW_PAGE    = 3'd1;
   localparam logic [2:0] OP_MARK_DIRTY  = 3'd2;
   localparam logic [2:0] OP_CLEAR_DIRTY = 3'd3;
   localparam logic [2:0] OP_FLUSH_ALL   = 3'd4;
   localparam logic [2:0] OP_RESET_DIRTY = 3'd5;
   localparam logic [2:0] OP_CLEAR_STATS = 3'd6;

   localparam logic CSR_WRITE_THROUGH = 1'b0;
   localparam logic CSR_SLOTS_IN_USE  = 1'b1;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  file_id;
      logic [31:0] page_number;
      logic [7:0]  file_handle;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_index;
      logic              hit;
      logic              fetch_needed;
      logic              writeback_valid;
      logic [7:0]        writeback_handle;
      logic [7:0]        writeback_file;
      logic [31:0]       writeback_page;
      logic [SLOT_W-1:0] writeback_slot;
      logic [31:0]       reads_total;
      logic [31:0]       hits_total;
      logic              last;
   } rsp_type;

endpackage

[rtl/page_buffer_lru_manager_core.sv]
// Top level of the page buffer LRU manager.
//
// Requests enter on req_valid/req_stall/req_data; results leave on
// rsp_valid/rsp_stall/rsp_data, one item per request, or one per dirty slot
// for flush all, the final one flagged by last. Registers are written on the
// csr_ port: index 0 write-through, index 1 slots in use.
// One item is worked at a time. Tags and recency ranks sit in two RAMs that
// are scanned one slot a cycle. A mark or clear dirty scans the n active
// slots, with an early exit on a hit. A read or new page scans the active
// slots, gives its result, then walks all SLOTS ranks to promote the slot.
// Flush all steps through the active slots up to the last dirty one and
// gives one item per dirty slot. Other items give their result from S_EMIT.
// Results wait in an output register while rsp_stall is high; the block holds
// its work until that register is free. Reset clears valid and dirty marks,
// counters and the write-through register and sets slots in use to 64, then a
// pass writes each slot's index as its rank in slot order while req_stall
// stays high.
`timescale 1ns / 1ps
module page_buffer_lru_manager_core #(
   parameter int SLOTS = pblm_pkg::SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  pblm_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output pblm_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [pblm_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   localparam int IW = $clog2(SLOTS);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SCAN = 4'd1;
   localparam logic [3:0] S_TRD  = 4'd2;
   localparam logic [3:0] S_TGT  = 4'd3;
   localparam logic [3:0] S_FRD  = 4'd4;
   localparam logic [3:0] S_FCHK = 4'd5;
   localparam logic [3:0] S_EMIT = 4'd6;
   localparam logic [3:0] S_RANK = 4'd7;
   localparam logic [3:0] S_INIT = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic [7:0]  file_ff, file_in;
   logic [31:0] page_ff, page_in;
   logic [7:0]  handle_ff, handle_in;
   logic [IW-1:0] scan_idx_ff, scan_idx_in;
   logic [IW-1:0] data_idx_ff, data_idx_in;
   logic          data_vld_ff, data_vld_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [IW-1:0] best_rank_ff, best_rank_in;
   logic [IW-1:0] tgt_ff, tgt_in;
   logic          found_ff, found_in;
   logic [IW-1:0] fl_idx_ff, fl_idx_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [SLOTS-1:0] dirty_ff, dirty_in;
   logic          wt_ff, wt_in;
   logic [pblm_pkg::CSR_DATA_W-1:0] siu_ff, siu_in;
   logic [31:0]   reads_ff, reads_in;
   logic [31:0]   hits_ff, hits_in;
   logic          rsp_valid_ff, rsp_valid_in;
   pblm_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                  ram_we;
   logic [IW-1:0]         ram_waddr, ram_raddr;
   logic [pblm_pkg::TAG_W-1:0] ram_wdata, ram_q;
   logic [7:0]  q_file, q_handle;
   logic [31:0] q_page;

   logic          rank_we;
   logic [IW-1:0] rank_waddr, rank_wdata, rank_q;

   logic [pblm_pkg::CSR_DATA_W-1:0] n_active;
   logic [IW-1:0]    last_idx;
   logic [SLOTS-1:0] active_mask, pend_vec;
   logic             more_pend;
   logic             out_free, accept;

   assign {q_file, q_page, q_handle} = ram_q;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   pblm_ram #(.WIDTH(pblm_pkg::TAG_W), .DEPTH(SLOTS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   pblm_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (rank_waddr),
      .wr_data (rank_wdata),
      .rd_addr (scan_idx_ff),
      .rd_data (rank_q)
   );

   always_comb begin
      if (siu_ff == '0) begin
         n_active = pblm_pkg::CSR_DATA_W'(1);
      end else if (siu_ff > pblm_pkg::CSR_DATA_W'(SLOTS)) begin
         n_active = pblm_pkg::CSR_DATA_W'(SLOTS);
      end else begin
         n_active = siu_ff;
      end
      last_idx = IW'(n_active - pblm_pkg::CSR_DATA_W'(1));
      for (int i = 0; i < SLOTS; i++) begin
         active_mask[i] = (pblm_pkg::CSR_DATA_W'(i) < n_active);
      end
      pend_vec  = valid_ff & dirty_ff & active_mask;
      more_pend = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (pend_vec[i] && (IW'(i) > fl_idx_ff)) begin
            more_pend = 1'b1;
         end
      end
   end

   always_comb begin
      unique case (state_ff)
         S_SCAN:        ram_raddr = scan_idx_ff;
         S_FRD, S_FCHK: ram_raddr = fl_idx_ff;
         default:       ram_raddr = tgt_ff;
      endcase
   end

   always_comb begin
      pblm_pkg::rsp_type e;
      logic          emit, match;
      logic [IW-1:0] vic, rmin;

      state_in = state_ff;
      op_in = op_ff; file_in = file_ff; page_in = page_ff; handle_in = handle_ff;
      scan_idx_in = scan_idx_ff; data_idx_in = data_idx_ff; data_vld_in = data_vld_ff;
      best_idx_in = best_idx_ff; best_rank_in = best_rank_ff;
      tgt_in = tgt_ff; found_in = found_ff; fl_idx_in = fl_idx_ff;
      valid_in = valid_ff; dirty_in = dirty_ff;
      wt_in = wt_ff; siu_in = siu_ff;
      reads_in = reads_ff; hits_in = hits_ff;
      ram_we = 1'b0; ram_waddr = tgt_ff; ram_wdata = {file_ff, page_ff, handle_ff};
      rank_we = 1'b0; rank_waddr = data_idx_ff; rank_wdata = rank_q - IW'(1);
      emit = 1'b0;
      e = '0;
      match = valid_ff[data_idx_ff] && (q_file == file_ff) && (q_page == page_ff);
      vic  = (rank_q < best_rank_ff) ? data_idx_ff : best_idx_ff;
      rmin = (rank_q < best_rank_ff) ? rank_q : best_rank_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            pblm_pkg::CSR_WRITE_THROUGH: wt_in  = csr_wr_data[0];
            pblm_pkg::CSR_SLOTS_IN_USE:  siu_in = csr_wr_data;
         endcase
      end

      unique case (state_ff)
         S_INIT: begin
            rank_we     = 1'b1;
            rank_waddr  = scan_idx_ff;
            rank_wdata  = scan_idx_ff;
            scan_idx_in = scan_idx_ff + IW'(1);
            if (scan_idx_ff == IW'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in = req_data.operation; file_in = req_data.file_id;
               page_in = req_data.page_number; handle_in = req_data.file_handle;
               scan_idx_in = '0; data_vld_in = 1'b0;
               best_idx_in = '0; best_rank_in = '1; fl_idx_in = '0;
               priority case (req_data.operation)
                  pblm_pkg::OP_READ: begin
                     reads_in = reads_ff + 32'd1;
                     state_in = S_SCAN;
                  end
                  pblm_pkg::OP_NEW_PAGE, pblm_pkg::OP_MARK_DIRTY,
                  pblm_pkg::OP_CLEAR_DIRTY: state_in = S_SCAN;
                  pblm_pkg::OP_FLUSH_ALL: state_in = (pend_vec == '0) ? S_EMIT : S_FRD;
                  pblm_pkg::OP_RESET_DIRTY: begin
                     dirty_in = dirty_ff & ~active_mask;
                     state_in = S_EMIT;
                  end
                  pblm_pkg::OP_CLEAR_STATS: begin
                     reads_in = '0; hits_in = '0;
                     state_in = S_EMIT;
                  end
                  default: state_in = S_EMIT;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_idx_ff != last_idx) begin
               scan_idx_in = scan_idx_ff + IW'(1);
            end
            data_vld_in = 1'b1;
            data_idx_in = scan_idx_ff;
            if (data_vld_ff) begin
               best_idx_in  = vic;
               best_rank_in = rmin;
               if (match || (data_idx_ff == last_idx)) begin
                  found_in     = match;
                  tgt_in       = match ? data_idx_ff : vic;
                  best_rank_in = match ? rank_q : rmin;
                  state_in     = S_TRD;
               end
            end
         end
         S_TRD: state_in = S_TGT;
         S_TGT: begin
            if (out_free) begin
               emit = 1'b1;
               e.last = 1'b1;
               state_in = S_IDLE;
               if ((op_ff == pblm_pkg::OP_READ) || (op_ff == pblm_pkg::OP_NEW_PAGE)) begin
                  state_in    = S_RANK;
                  scan_idx_in = '0;
                  data_vld_in = 1'b0;
                  e.slot_index = pblm_pkg::SLOT_W'(tgt_ff);
                  ram_we = 1'b1;
                  if (found_ff) begin
                     e.hit = 1'b1;
                     if (op_ff == pblm_pkg::OP_READ) begin
                        hits_in = hits_ff + 32'd1;
                        ram_we  = 1'b0;
                     end else begin
                        dirty_in[tgt_ff] = 1'b1;
                     end
                  end else begin
                     e.fetch_needed = (op_ff == pblm_pkg::OP_READ);
                     if (valid_ff[tgt_ff] && dirty_ff[tgt_ff]) begin
                        e.writeback_valid  = 1'b1;
                        e.writeback_handle = q_handle;
                        e.writeback_file   = q_file;
                        e.writeback_page   = q_page;
                        e.writeback_slot   = pblm_pkg::SLOT_W'(tgt_ff);
                     end
                     valid_in[tgt_ff] = 1'b1;
                     dirty_in[tgt_ff] = (op_ff == pblm_pkg::OP_NEW_PAGE);
                  end
               end else if (found_ff) begin
                  e.slot_index = pblm_pkg::SLOT_W'(tgt_ff);
                  e.hit = 1'b1;
                  if ((op_ff == pblm_pkg::OP_MARK_DIRTY) && wt_ff) begin
                     e.writeback_valid  = 1'b1;
                     e.writeback_handle = q_handle;
                     e.writeback_file   = q_file;
                     e.writeback_page   = q_page;
                     e.writeback_slot   = pblm_pkg::SLOT_W'(tgt_ff);
                  end else begin
                     dirty_in[tgt_ff] = (op_ff == pblm_pkg::OP_MARK_DIRTY);
                  end
               end
            end
         end
         S_RANK: begin
            if (scan_idx_ff != IW'(SLOTS - 1)) begin
               scan_idx_in = scan_idx_ff + IW'(1);
            end
            data_vld_in = 1'b1;
            data_idx_in = scan_idx_ff;
            if (data_vld_ff) begin
               if (data_idx_ff == tgt_ff) begin
                  rank_we    = 1'b1;
                  rank_wdata = IW'(SLOTS - 1);
               end else if (rank_q > best_rank_ff) begin
                  rank_we = 1'b1;
               end
               if (data_idx_ff == IW'(SLOTS - 1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FRD: begin
            if (pend_vec[fl_idx_ff]) begin
               state_in = S_FCHK;
            end else begin
               fl_idx_in = fl_idx_ff + IW'(1);
            end
         end
         S_FCHK: begin
            if (out_free) begin
               emit = 1'b1;
               e.slot_index       = pblm_pkg::SLOT_W'(fl_idx_ff);
               e.writeback_valid  = 1'b1;
               e.writeback_handle = q_handle;
               e.writeback_file   = q_file;
               e.writeback_page   = q_page;
               e.writeback_slot   = pblm_pkg::SLOT_W'(fl_idx_ff);
               e.last             = !more_pend;
               dirty_in[fl_idx_ff] = 1'b0;
               if (more_pend) begin
                  fl_idx_in = fl_idx_ff + IW'(1);
                  state_in  = S_FRD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               emit = 1'b1;
               e.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      e.reads_total = reads_in;
      e.hits_total  = hits_in;
      rsp_data_in   = emit ? e : rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         scan_idx_ff  <= '0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         wt_ff        <= 1'b0;
         siu_ff       <= pblm_pkg::CSR_DATA_W'(64);
         reads_ff     <= '0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         wt_ff        <= wt_in;
         siu_ff       <= siu_in;
         reads_ff     <= reads_in;
         hits_ff      <= hits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      file_ff      <= file_in;
      page_ff      <= page_in;
      handle_ff    <= handle_in;
      data_idx_ff  <= data_idx_in;
      data_vld_ff  <= data_vld_in;
      best_idx_ff  <= best_idx_in;
      best_rank_ff <= best_rank_in;
      tgt_ff       <= tgt_in;
      found_ff     <= found_in;
      fl_idx_ff    <= fl_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end
endmodule

[rtl/pblm_ram.sv]
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module pblm_ram #(
   parameter int WIDTH = pblm_pkg::TAG_W,
   parameter int DEPTH = pblm_pkg::SLOTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/pblm_checker.sv]
// Port-level assertions of the page buffer LRU manager and their binding.
`timescale 1ns / 1ps
module pblm_checker (
   input logic              clock,
   input logic              reset,
   input pblm_pkg::rsp_type rsp_data,
   input logic              rsp_valid,
   input logic              rsp_stall
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item shown after reset");

   a_fetch_not_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.fetch_needed && rsp_data.hit))
      else $error("fetch requested on a hit");

   a_wb_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.writeback_valid |->
         rsp_data.writeback_slot == '0 && rsp_data.writeback_page == '0)
      else $error("write-back fields set without write-back");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result item changed while stalled");
endmodule

bind page_buffer_lru_manager_core pblm_checker u_pblm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);

[tb/tb_page_buffer_lru_manager_core.sv]
// Self-checking testbench of the page buffer LRU manager core.
`timescale 1ns / 1ps
module tb_page_buffer_lru_manager_core;

   localparam int NSLOT = 64;
   localparam int WATCHDOG_LIMIT = 20000;

   class lru_scoreboard;
      bit          wt;
      int unsigned active;
      bit          vld [NSLOT];
      bit          drt [NSLOT];
      logic [7:0]  fil [NSLOT];
      logic [31:0] pg  [NSLOT];
      logic [7:0]  hnd [NSLOT];
      int unsigned rank [NSLOT];
      logic [31:0] reads, hits;
      pblm_pkg::rsp_type pending [$];
      int          errors;
      int          results;

      function new();
         wt = 0;
         active = NSLOT;
         reads = 0;
         hits = 0;
         errors = 0;
         results = 0;
         for (int i = 0; i < NSLOT; i++) begin
            vld[i] = 0;
            drt[i] = 0;
            fil[i] = 0;
            pg[i] = 0;
            hnd[i] = 0;
            rank[i] = i;
         end
      endfunction

      function void set_reg(bit idx, logic [6:0] val);
         if (idx == pblm_pkg::CSR_WRITE_THROUGH) wt = val[0];
         else active = (val == 0) ? 1 : ((val > NSLOT) ? NSLOT : val);
      endfunction

      function int find_slot(logic [7:0] f, logic [31:0] p);
         for (int i = 0; i < active; i++)
            if (vld[i] && fil[i] == f && pg[i] == p) return i;
         return -1;
      endfunction

      function void promote(int s);
         int unsigned r;
         r = rank[s];
         for (int i = 0; i < NSLOT; i++)
            if (rank[i] > r) rank[i]--;
         rank[s] = NSLOT - 1;
      endfunction

      function void push_result(int slot, bit h, bit fe, bit wb, int ws);
         pblm_pkg::rsp_type r;
         r = '0;
         r.slot_index = pblm_pkg::SLOT_W'(slot);
         r.hit = h;
         r.fetch_needed = fe;
         r.writeback_valid = wb;
         if (wb) begin
            r.writeback_handle = hnd[ws];
            r.writeback_file = fil[ws];
            r.writeback_page = pg[ws];
            r.writeback_slot = pblm_pkg::SLOT_W'(ws);
         end
         r.reads_total = reads;
         r.hits_total = hits;
         pending.push_back(r);
      endfunction

      function void note_request(pblm_pkg::req_type q);
         int s, v, n0;
         n0 = pending.size();
         case (q.operation)
            pblm_pkg::OP_READ, pblm_pkg::OP_NEW_PAGE: begin
               if (q.operation == pblm_pkg::OP_READ) reads++;
               s = find_slot(q.file_id, q.page_number);
               if (s >= 0) begin
                  promote(s);
                  if (q.operation == pblm_pkg::OP_READ) hits++;
                  else begin
                     drt[s] = 1;
                     hnd[s] = q.file_handle;
                  end
                  push_result(s, 1, 0, 0, 0);
               end else begin
                  v = 0;
                  for (int i = 1; i < active; i++)
                     if (rank[i] < rank[v]) v = i;
                  push_result(v, 0, q.operation == pblm_pkg::OP_READ, vld[v] && drt[v], v);
                  vld[v] = 1;
                  drt[v] = (q.operation == pblm_pkg::OP_NEW_PAGE);
                  fil[v] = q.file_id;
                  pg[v] = q.page_number;
                  hnd[v] = q.file_handle;
                  promote(v);
               end
            end
            pblm_pkg::OP_MARK_DIRTY, pblm_pkg::OP_CLEAR_DIRTY: begin
               s = find_slot(q.file_id, q.page_number);
               if (s < 0) push_result(0, 0, 0, 0, 0);
               else if (q.operation == pblm_pkg::OP_MARK_DIRTY && wt) push_result(s, 1, 0, 1, s);
               else begin
                  drt[s] = (q.operation == pblm_pkg::OP_MARK_DIRTY);
                  push_result(s, 1, 0, 0, 0);
               end
            end
            pblm_pkg::OP_FLUSH_ALL: begin
               for (int i = 0; i < active; i++)
                  if (vld[i] && drt[i]) begin
                     drt[i] = 0;
                     push_result(i, 0, 0, 1, i);
                  end
               if (pending.size() == n0) push_result(0, 0, 0, 0, 0);
            end
            pblm_pkg::OP_RESET_DIRTY: begin
               for (int i = 0; i < active; i++) drt[i] = 0;
               push_result(0, 0, 0, 0, 0);
            end
            pblm_pkg::OP_CLEAR_STATS: begin
               reads = 0;
               hits = 0;
               push_result(0, 0, 0, 0, 0);
            end
            default: push_result(0, 0, 0, 0, 0);
         endcase
         pending[pending.size()-1].last = 1;
      endfunction

      function void check_result(pblm_pkg::rsp_type got);
         pblm_pkg::rsp_type want;
         results++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: slot %0d/%0d hit %b/%b fetch %b/%b wb %b/%b",
                         " h %h/%h f %h/%h p %h/%h ws %0d/%0d rd %0d/%0d ht %0d/%0d",
                         " last %b/%b"},
                  want.slot_index, got.slot_index, want.hit, got.hit,
                  want.fetch_needed, got.fetch_needed, want.writeback_valid,
                  got.writeback_valid, want.writeback_handle, got.writeback_handle,
                  want.writeback_file, got.writeback_file, want.writeback_page,
                  got.writeback_page, want.writeback_slot, got.writeback_slot,
                  want.reads_total, got.reads_total, want.hits_total, got.hits_total,
                  want.last, got.last);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   pblm_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   pblm_pkg::rsp_type rsp_data;
   logic csr_wr_en = 0;
   logic csr_index = 0;
   logic [pblm_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;

   lru_scoreboard board = new();
   int send_idle = 0, recv_idle = 0;
   bit hold_off = 0;
   int idle_cycles = 0;
   int sent = 0;
   logic [7:0] key_file [8];
   logic [31:0] key_page [8];

   always #5 clock = ~clock;

   page_buffer_lru_manager_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("page_buffer_lru_manager_core test failed");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1;
      else rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   task automatic send_item(pblm_pkg::req_type q);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(q);
      sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(bit idx, logic [6:0] val);
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      board.set_reg(idx, val);
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   function automatic pblm_pkg::req_type make_item(logic [2:0] op, logic [7:0] f,
                                                   logic [31:0] p, logic [7:0] h);
      pblm_pkg::req_type q;
      q.operation = op;
      q.file_id = f;
      q.page_number = p;
      q.file_handle = h;
      return q;
   endfunction

   function automatic pblm_pkg::req_type random_item();
      int k;
      logic [2:0] op;
      k = $urandom_range(7);
      case ($urandom_range(9))
         0, 1, 2, 3: op = pblm_pkg::OP_READ;
         4, 5: op = pblm_pkg::OP_NEW_PAGE;
         6: op = pblm_pkg::OP_MARK_DIRTY;
         7: op = pblm_pkg::OP_CLEAR_DIRTY;
         8: op = ($urandom_range(3) == 0) ? pblm_pkg::OP_RESET_DIRTY : pblm_pkg::OP_FLUSH_ALL;
         default: op = 3'($urandom_range(7));
      endcase
      if ($urandom_range(4) == 0)
         return make_item(op, 8'($urandom), $urandom, 8'($urandom));
      return make_item(op, key_file[k], key_page[k], 8'($urandom));
   endfunction

   initial begin
      int phase_idle [4][2];
      logic [6:0] sizes [4];
      phase_idle = '{'{0, 0}, '{71, 0}, '{0, 71}, '{21, 21}};
      sizes = '{7'd64, 7'd1, 7'd3, 7'd0};
      for (int i = 0; i < 8; i++) begin
         key_file[i] = 8'($urandom);
         key_page[i] = $urandom;
      end
      key_file[0] = 8'hFF;
      key_page[0] = 32'hFFFF_FFFF;
      key_file[1] = 8'h00;
      key_page[1] = 32'h0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send_item(make_item(pblm_pkg::OP_FLUSH_ALL, 8'h00, 32'h0, 8'h00));
      send_item(make_item(pblm_pkg::OP_MARK_DIRTY, 8'hFF, 32'hFFFF_FFFF, 8'hFF));
      send_item(make_item(pblm_pkg::OP_READ, 8'hFF, 32'hFFFF_FFFF, 8'hFF));
      send_item(make_item(pblm_pkg::OP_READ, 8'hFF, 32'hFFFF_FFFF, 8'h00));
      send_item(make_item(pblm_pkg::OP_NEW_PAGE, 8'h00, 32'h0, 8'hA5));
      send_item(make_item(pblm_pkg::OP_NEW_PAGE, 8'h00, 32'h0, 8'h5A));
      send_item(make_item(pblm_pkg::OP_MARK_DIRTY, 8'hFF, 32'hFFFF_FFFF, 8'h00));
      send_item(make_item(pblm_pkg::OP_CLEAR_DIRTY, 8'h00, 32'h0, 8'h00));
      send_item(make_item(pblm_pkg::OP_CLEAR_DIRTY, 8'h12, 32'h34, 8'h00));
      send_item(make_item(pblm_pkg::OP_FLUSH_ALL, 8'h00, 32'h0, 8'h00));
      send_item(make_item(pblm_pkg::OP_NEW_PAGE, 8'h01, 32'h1, 8'h01));
      send_item(make_item(pblm_pkg::OP_RESET_DIRTY, 8'h00, 32'h0, 8'h00));
      send_item(make_item(pblm_pkg::OP_FLUSH_ALL, 8'h00, 32'h0, 8'h00));
      send_item(make_item(pblm_pkg::OP_CLEAR_STATS, 8'h00, 32'h0, 8'h00));
      send_item(make_item(3'd7, 8'hFF, 32'hFFFF_FFFF, 8'hFF));
      write_reg(pblm_pkg::CSR_WRITE_THROUGH, 7'd1);
      send_item(make_item(pblm_pkg::OP_MARK_DIRTY, 8'h01, 32'h1, 8'h00));
      write_reg(pblm_pkg::CSR_SLOTS_IN_USE, 7'd2);
      for (int i = 0; i < 4; i++)
         send_item(make_item(pblm_pkg::OP_NEW_PAGE, 8'(i), 32'(i), 8'(i)));
      send_item(make_item(pblm_pkg::OP_FLUSH_ALL, 8'h00, 32'h0, 8'h00));
      write_reg(pblm_pkg::CSR_SLOTS_IN_USE, 7'd127);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle = phase_idle[ph][0];
         recv_idle = phase_idle[ph][1];
         write_reg(pblm_pkg::CSR_WRITE_THROUGH, 7'($urandom_range(1)));
         write_reg(pblm_pkg::CSR_SLOTS_IN_USE, sizes[ph]);
         if (ph == 1) begin
            fork
               begin
                  hold_off = 1;
                  repeat (300) @(negedge clock);
                  hold_off = 0;
               end
            join_none
         end
         for (int i = 0; i < 22; i++) send_item(random_item());
      end
      send_idle = 0;
      write_reg(pblm_pkg::CSR_SLOTS_IN_USE, 7'd64);
      for (int i = 0; i < 12; i++)
         send_item(make_item(pblm_pkg::OP_NEW_PAGE, 8'($urandom), $urandom, 8'($urandom)));
      send_item(make_item(pblm_pkg::OP_FLUSH_ALL, 8'h00, 32'h0, 8'h00));
      req_valid <= 0;

      while (board.pending.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("covered %0d items and %0d results over four idling phases", sent, board.results);
      $display("slot counts 1 to 64, write-through on and off, flush and eviction write-backs");
      if (board.errors == 0 && board.pending.size() == 0)
         $display("page_buffer_lru_manager_core test passed");
      else
         $display("page_buffer_lru_manager_core test failed");
      $finish;
   end
endmodule

[files.f]
rtl/pblm_pkg.sv
rtl/pblm_ram.sv
rtl/page_buffer_lru_manager_core.sv
rtl/pblm_checker.sv
tb/tb_page_buffer_lru_manager_core.sv
